>>> hdl/wlbgr_pkg.sv
package wlbgr_pkg;

  // field widths
  localparam int SampleW = 17;
  localparam int DiffW   = 18;
  localparam int GainW   = 20;
  localparam int DimW    = 13;
  localparam int ProdW   = 37;
  localparam int FracW   = 12;
  localparam int PadW    = 2;

  // widest kept row; display_width is capped here
  localparam logic [DimW:0] MaxLine = 14'd4096;
  localparam logic [DimW-1:0] CntMax = 13'd8191;

  // force_level codes
  localparam logic [1:0] FORCE_NONE  = 2'd0;
  localparam logic [1:0] FORCE_BLACK = 2'd1;
  localparam logic [1:0] FORCE_WHITE = 2'd2;

  // register indexes
  localparam logic [2:0] REG_COLOR_MODE  = 3'd0;
  localparam logic [2:0] REG_FORCE_LEVEL = 3'd1;
  localparam logic [2:0] REG_LOW_THRESH  = 3'd2;
  localparam logic [2:0] REG_HIGH_THRESH = 3'd3;
  localparam logic [2:0] REG_BLACK_OFS   = 3'd4;
  localparam logic [2:0] REG_GAIN        = 3'd5;
  localparam logic [2:0] REG_DISP_WIDTH  = 3'd6;
  localparam logic [2:0] REG_DISP_HEIGHT = 3'd7;

  // per-sample class found in the first lane stage
  typedef enum logic [1:0] {
    CLS_ZERO  = 2'd0,
    CLS_FULL  = 2'd1,
    CLS_SCALE = 2'd2
  } sample_cls_t;

  // transfer settings shared by the lanes
  typedef struct packed {
    logic [1:0]                force_level;
    logic signed [SampleW-1:0] low_threshold;
    logic signed [SampleW-1:0] high_threshold;
    logic signed [SampleW-1:0] black_offset;
    logic [GainW-1:0]          gain_q12;
  } map_cfg_t;

  // crop settings for the row/frame tracker
  typedef struct packed {
    logic            color_mode;
    logic [DimW-1:0] display_width;
    logic [DimW-1:0] display_height;
  } crop_cfg_t;

  // row/frame sideband that travels beside the lanes
  typedef struct packed {
    logic [PadW-1:0] pad_after;
    logic            row_end;
    logic            frame_end;
  } side_t;

  function automatic logic [DimW-1:0] sat_inc(input logic [DimW-1:0] c);
    sat_inc = (c >= CntMax) ? CntMax : c + 1'b1;
  endfunction

endpackage

>>> hdl/wlbgr_lane.sv
module wlbgr_lane (
  input  logic                               clk,
  input  logic                               en_cls,
  input  logic                               en_mul,
  input  logic signed [wlbgr_pkg::SampleW-1:0] sample,
  input  wlbgr_pkg::map_cfg_t                cfg,
  output logic [7:0]                         byte_out
);
  import wlbgr_pkg::*;

  sample_cls_t              cls_r, cls_nxt;
  logic [SampleW-1:0]       mag_r, mag_nxt;
  sample_cls_t              pcls_r;
  logic [ProdW-1:0]         prod_r;
  logic signed [DiffW-1:0]  diff;
  logic [ProdW-FracW-1:0]   scaled;

  // classify the sample and take the offset difference
  always_comb begin
    diff = DiffW'(sample) - DiffW'(cfg.black_offset);
    mag_nxt = diff[SampleW-1:0];
    if (cfg.force_level == FORCE_BLACK) begin
      cls_nxt = CLS_ZERO;
    end else if (cfg.force_level == FORCE_WHITE) begin
      cls_nxt = CLS_FULL;
    end else if (sample < cfg.low_threshold) begin
      cls_nxt = CLS_ZERO;
    end else if (sample >= cfg.high_threshold) begin
      cls_nxt = CLS_FULL;
    end else if (diff[DiffW-1] || (diff == '0)) begin
      cls_nxt = CLS_ZERO;
    end else begin
      cls_nxt = CLS_SCALE;
    end
  end

  always_ff @(posedge clk) begin
    if (en_cls) begin
      cls_r <= cls_nxt;
      mag_r <= mag_nxt;
    end
  end

  // gain multiply
  always_ff @(posedge clk) begin
    if (en_mul) begin
      pcls_r <= cls_r;
      prod_r <= ProdW'(mag_r) * ProdW'(cfg.gain_q12);
    end
  end

  // drop the fraction and saturate to a byte
  always_comb begin
    scaled = prod_r[ProdW-1:FracW];
    case (pcls_r)
      CLS_ZERO:  byte_out = 8'd0;
      CLS_FULL:  byte_out = 8'd255;
      CLS_SCALE: byte_out = (|scaled[ProdW-FracW-1:8]) ? 8'd255 : scaled[7:0];
      default:   byte_out = 8'd0;
    endcase
  end

endmodule

>>> hdl/wlbgr_frame.sv
module wlbgr_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 row_last,
  input  logic                 frame_last,
  input  wlbgr_pkg::crop_cfg_t cfg,
  output logic                 emit,
  output wlbgr_pkg::side_t     side
);
  import wlbgr_pkg::*;

  logic [DimW-1:0] col_r, col_nxt;
  logic [DimW-1:0] row_r, row_nxt;
  logic [DimW-1:0] kept_w;
  logic            ends;
  logic            rend;
  logic            fend;

  // crop decision and row/frame end flags
  always_comb begin
    ends   = row_last || frame_last;
    kept_w = ({1'b0, cfg.display_width} > MaxLine) ? DimW'(MaxLine) : cfg.display_width;
    if (cfg.color_mode) begin
      emit = 1'b1;
      rend = ends;
      fend = frame_last;
    end else begin
      emit = (col_r < kept_w) && (row_r < cfg.display_height);
      rend = ends || (({1'b0, col_r} + 1'b1) == {1'b0, kept_w});
      fend = frame_last ||
             (rend && (({1'b0, row_r} + 1'b1) == {1'b0, cfg.display_height}));
    end
    side.row_end   = rend;
    side.frame_end = fend;
    side.pad_after = rend ? (col_r[PadW-1:0] + 1'b1) : '0;
  end

  // column and row counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (ends) begin
        col_nxt = '0;
        row_nxt = frame_last ? '0 : sat_inc(row_r);
      end else begin
        col_nxt = sat_inc(col_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

>>> hdl/window_level_to_bgr24_top.sv
// an accepted pixel passes the class, multiply and output registers before it reaches the output
// one pixel per cycle unless out_tready stalls; each of three lanes has one 17x20 multiplier
// cropped pixels take an input slot but give no output request
// reset: synchronous, active low; clears pipeline valids, row/column counters and
// returns every configuration register to its default
module window_level_to_bgr24_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write port
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [wlbgr_pkg::GainW-1:0] cfg_wdata,
  // input pixels
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [55:0]                 in_tdata,  // gray_or_red, green_sample, blue_sample
  input  logic                        in_tlast,  // row_last
  input  logic                        in_tuser,  // frame_last
  // output bgr bytes
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata, // blue_byte, green_byte, red_byte, pad_after
  output logic                        out_tlast, // row_end
  output logic                        out_tuser  // frame_end
);
  import wlbgr_pkg::*;

  // configuration registers
  logic                       color_mode_r;
  logic [1:0]                 force_level_r;
  logic signed [SampleW-1:0]  low_thr_r;
  logic signed [SampleW-1:0]  high_thr_r;
  logic signed [SampleW-1:0]  black_ofs_r;
  logic [GainW-1:0]           gain_r;
  logic [DimW-1:0]            disp_w_r;
  logic [DimW-1:0]            disp_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r  <= 1'b0;
      force_level_r <= FORCE_NONE;
      low_thr_r     <= '0;
      high_thr_r    <= SampleW'(255);
      black_ofs_r   <= '0;
      gain_r        <= GainW'(4096);
      disp_w_r      <= DimW'(256);
      disp_h_r      <= DimW'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLOR_MODE:  color_mode_r  <= cfg_wdata[0];
        REG_FORCE_LEVEL: force_level_r <= cfg_wdata[1:0];
        REG_LOW_THRESH:  low_thr_r     <= cfg_wdata[SampleW-1:0];
        REG_HIGH_THRESH: high_thr_r    <= cfg_wdata[SampleW-1:0];
        REG_BLACK_OFS:   black_ofs_r   <= cfg_wdata[SampleW-1:0];
        REG_GAIN:        gain_r        <= cfg_wdata;
        REG_DISP_WIDTH:  disp_w_r      <= cfg_wdata[DimW-1:0];
        REG_DISP_HEIGHT: disp_h_r      <= cfg_wdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  map_cfg_t  map_cfg;
  crop_cfg_t crop_cfg;

  assign map_cfg.force_level    = force_level_r;
  assign map_cfg.low_threshold  = low_thr_r;
  assign map_cfg.high_threshold = high_thr_r;
  assign map_cfg.black_offset   = black_ofs_r;
  assign map_cfg.gain_q12       = gain_r;
  assign crop_cfg.color_mode     = color_mode_r;
  assign crop_cfg.display_width  = disp_w_r;
  assign crop_cfg.display_height = disp_h_r;

  // pipeline handshake: each stage moves when the one after it is empty or moving
  logic  s1_v_r, s1_v_nxt;
  logic  s2_v_r, s2_v_nxt;
  logic  out_v_r, out_v_nxt;
  logic  out_adv, s2_adv, s1_adv;
  logic  accept;
  logic  emit;
  side_t side_in;
  side_t s1_side_r, s2_side_r, out_side_r;

  assign out_adv   = !out_v_r || out_tready;
  assign s2_adv    = !s2_v_r || out_adv;
  assign s1_adv    = !s1_v_r || s2_adv;
  assign in_tready = s1_adv;
  assign accept    = in_tvalid && in_tready;

  assign s1_v_nxt  = s1_adv ? (accept && emit) : s1_v_r;
  assign s2_v_nxt  = s2_adv ? s1_v_r : s2_v_r;
  assign out_v_nxt = out_adv ? s2_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // row/frame tracking and crop
  wlbgr_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .row_last   (in_tlast),
    .frame_last (in_tuser),
    .cfg        (crop_cfg),
    .emit       (emit),
    .side       (side_in)
  );

  // sideband follows the lanes
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_side_r <= side_in;
    end
    if (s2_adv) begin
      s2_side_r <= s1_side_r;
    end
  end

  // three mapping lanes
  logic [7:0] red_lane, green_lane, blue_lane;

  wlbgr_lane u_lane_red (
    .clk      (clk),
    .en_cls   (s1_adv),
    .en_mul   (s2_adv),
    .sample   (in_tdata[SampleW-1:0]),
    .cfg      (map_cfg),
    .byte_out (red_lane)
  );

  wlbgr_lane u_lane_green (
    .clk      (clk),
    .en_cls   (s1_adv),
    .en_mul   (s2_adv),
    .sample   (in_tdata[2*SampleW-1:SampleW]),
    .cfg      (map_cfg),
    .byte_out (green_lane)
  );

  wlbgr_lane u_lane_blue (
    .clk      (clk),
    .en_cls   (s1_adv),
    .en_mul   (s2_adv),
    .sample   (in_tdata[3*SampleW-1:2*SampleW]),
    .cfg      (map_cfg),
    .byte_out (blue_lane)
  );

  // merge: gray mode copies the first lane to all three bytes
  logic [7:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (out_adv && s2_v_r) begin
      red_r      <= red_lane;
      green_r    <= color_mode_r ? green_lane : red_lane;
      blue_r     <= color_mode_r ? blue_lane : red_lane;
      out_side_r <= s2_side_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, out_side_r.pad_after, red_r, green_r, blue_r};
  assign out_tlast  = out_side_r.row_end;
  assign out_tuser  = out_side_r.frame_end;

endmodule
